>>> design/msb_pkg.sv
// ----------------------------------------------------------------------------
// msb_pkg
// Shared types and constants for the multi-stack shared buffer.
// ----------------------------------------------------------------------------
package msb_pkg;

   // Fixed field widths of the request and response beats
   localparam int OP_W     = 1;
   localparam int SID_W    = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   // Operation codes
   localparam logic [OP_W-1:0] OP_PUSH = 1'b0;
   localparam logic [OP_W-1:0] OP_POP  = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;

   // Sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } msb_state_type;

   // Strobes from the sequencer output decode
   typedef struct packed {
      logic req_stall;
      logic accept;
      logic exec_fire;
   } msb_ctrl_type;

endpackage

>>> design/msb_ram.sv
// ----------------------------------------------------------------------------
// msb_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module msb_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Hold the last read until the next read enable
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/multi_stack_shared_buffer_core.sv
// ----------------------------------------------------------------------------
// multi_stack_shared_buffer_core
// Several LIFO stacks threaded as linked lists through one shared slot store.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one beat is a push (req_op = push, req_value) or
//   a pop on stack req_stack_id. Response channel (rsp_*): exactly one beat
//   per request, in order, with rsp_status ok / overflow / empty and the
//   popped item on rsp_read_value (zero unless a pop succeeds).
//   A request is held in registers until its write cycle, which loads the
//   response register; a new request is accepted only after it. The edge
//   that accepts a request reads the target slot's link and data from the
//   RAMs; the write cycle uses that registered read data to write both RAMs,
//   the head registers and the response register. The request channel is
//   stalled in the write cycle, so reads and writes to one slot never overlap.
//   The response sits in its own register, so a new request is accepted while
//   an earlier response still waits. If the receiver stalls and the register
//   is still full when the next request reaches its write cycle, that request
//   holds in place (and req_stall stays high) until the register frees.
//   Reset: synchronous, active high. All stacks go empty and the free list
//   covers every slot in order. There is no clearing pass: a fill count marks
//   the slots whose link was never written, which read as "next slot".
// ----------------------------------------------------------------------------
module multi_stack_shared_buffer_core #(
   parameter int NUM_STACKS = 4,
   parameter int NUM_SLOTS  = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [msb_pkg::OP_W-1:0]            req_op,
   input  logic [msb_pkg::SID_W-1:0]           req_stack_id,
   input  logic signed [msb_pkg::VALUE_W-1:0]  req_value,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [msb_pkg::VALUE_W-1:0]  rsp_read_value,
   output logic [msb_pkg::STATUS_W-1:0]        rsp_status
);

   // Pointer holds 0 .. NUM_SLOTS, where NUM_SLOTS is null
   localparam int PTR_W  = $clog2(NUM_SLOTS + 1);
   localparam int ADDR_W = $clog2(NUM_SLOTS);
   // Only stacks a request can name need a head register
   localparam int SID_SPAN = 1 << msb_pkg::SID_W;
   localparam int HEAD_N   = (NUM_STACKS < SID_SPAN) ? NUM_STACKS : SID_SPAN;
   localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(NUM_SLOTS);

   // ---------------------------------------------------------------------
   // Control state
   // ---------------------------------------------------------------------
   msb_pkg::msb_state_type state_ff, state_in;
   msb_pkg::msb_ctrl_type  ctrl;

   logic [PTR_W-1:0] head_ff [HEAD_N];
   logic [PTR_W-1:0] head_in [HEAD_N];
   logic [PTR_W-1:0] free_head_ff, free_head_in;
   logic [PTR_W-1:0] fill_ff, fill_in;

   // Request held across the write cycle
   logic [msb_pkg::OP_W-1:0]    op_ff;
   logic [msb_pkg::SID_W-1:0]   sid_ff;
   logic [msb_pkg::VALUE_W-1:0] value_ff;
   logic [PTR_W-1:0]            slot_ff;
   logic                        go_ff;

   // Response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [msb_pkg::VALUE_W-1:0]   rsp_read_value_ff, rsp_read_value_in;
   logic [msb_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   logic out_free;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         msb_pkg::ST_IDLE: begin
            if (req_valid && !reset) begin
               state_in = msb_pkg::ST_EXEC;
            end
         end
         msb_pkg::ST_EXEC: begin
            if (out_free) begin
               state_in = msb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = msb_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl = '0;
      case (state_ff)
         msb_pkg::ST_IDLE: begin
            ctrl.req_stall = reset;
            ctrl.accept    = req_valid && !reset;
         end
         msb_pkg::ST_EXEC: begin
            ctrl.req_stall = 1'b1;
            ctrl.exec_fire = out_free;
         end
         default: begin
            ctrl.req_stall = 1'b1;
         end
      endcase
   end

   assign req_stall = ctrl.req_stall;

   // ---------------------------------------------------------------------
   // Accept cycle: pick the target slot and issue the RAM reads
   // ---------------------------------------------------------------------
   logic             sid_ok;
   logic [PTR_W-1:0] req_head;
   logic [PTR_W-1:0] req_slot;

   assign sid_ok = (32'(req_stack_id) < NUM_STACKS);

   always_comb begin
      req_head = NULL_PTR;
      for (int i = 0; i < HEAD_N; i++) begin
         if (req_stack_id == msb_pkg::SID_W'(i)) begin
            req_head = head_ff[i];
         end
      end
   end

   // Push takes the free-list head, pop takes the stack top
   assign req_slot = (req_op == msb_pkg::OP_PUSH) ? free_head_ff : req_head;

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         op_ff    <= req_op;
         sid_ff   <= req_stack_id;
         value_ff <= req_value;
         slot_ff  <= req_slot;
         go_ff    <= sid_ok && (req_slot < NULL_PTR);
      end
   end

   // ---------------------------------------------------------------------
   // Slot stores
   // ---------------------------------------------------------------------
   logic                  link_we;
   logic [PTR_W-1:0]      link_wdata;
   logic [PTR_W-1:0]      link_q;
   logic                  data_we;
   logic [DATA_WIDTH-1:0] data_wdata;
   logic [DATA_WIDTH-1:0] data_q;
   logic [msb_pkg::VALUE_W-1:0] data_q_ext;

   msb_ram #(
      .WIDTH  (PTR_W),
      .DEPTH  (NUM_SLOTS),
      .ADDR_W (ADDR_W)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (slot_ff[ADDR_W-1:0]),
      .wr_data (link_wdata),
      .rd_en   (ctrl.accept),
      .rd_addr (req_slot[ADDR_W-1:0]),
      .rd_data (link_q)
   );

   msb_ram #(
      .WIDTH  (DATA_WIDTH),
      .DEPTH  (NUM_SLOTS),
      .ADDR_W (ADDR_W)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (slot_ff[ADDR_W-1:0]),
      .wr_data (data_wdata),
      .rd_en   (ctrl.accept),
      .rd_addr (req_slot[ADDR_W-1:0]),
      .rd_data (data_q)
   );

   // Fit the item to the store width and back
   if (DATA_WIDTH > msb_pkg::VALUE_W) begin : g_wide
      assign data_wdata = {{(DATA_WIDTH - msb_pkg::VALUE_W){1'b0}}, value_ff};
      assign data_q_ext = data_q[msb_pkg::VALUE_W-1:0];
   end else if (DATA_WIDTH == msb_pkg::VALUE_W) begin : g_equal
      assign data_wdata = value_ff;
      assign data_q_ext = data_q;
   end else begin : g_narrow
      assign data_wdata = value_ff[DATA_WIDTH-1:0];
      assign data_q_ext = {{(msb_pkg::VALUE_W - DATA_WIDTH){1'b0}}, data_q};
   end

   // ---------------------------------------------------------------------
   // Write cycle: relink, update heads, load the response
   // ---------------------------------------------------------------------
   logic             is_push;
   logic             push_ok;
   logic             pop_ok;
   logic             fresh;
   logic [PTR_W-1:0] link_eff;
   logic [PTR_W-1:0] cur_head;

   assign is_push = (op_ff == msb_pkg::OP_PUSH);
   assign push_ok = ctrl.exec_fire && is_push && go_ff;
   assign pop_ok  = ctrl.exec_fire && !is_push && go_ff;

   // A slot at or past the fill count was never relinked: it links to the next
   assign fresh    = (slot_ff >= fill_ff);
   assign link_eff = fresh ? PTR_W'(slot_ff + PTR_W'(1)) : link_q;

   always_comb begin
      cur_head = NULL_PTR;
      for (int i = 0; i < HEAD_N; i++) begin
         if (sid_ff == msb_pkg::SID_W'(i)) begin
            cur_head = head_ff[i];
         end
      end
   end

   assign link_we    = push_ok || pop_ok;
   assign link_wdata = is_push ? cur_head : free_head_ff;
   assign data_we    = push_ok;

   always_comb begin
      free_head_in = free_head_ff;
      fill_in      = fill_ff;
      for (int i = 0; i < HEAD_N; i++) begin
         head_in[i] = head_ff[i];
      end
      if (push_ok) begin
         free_head_in = link_eff;
         if (fresh) begin
            fill_in = PTR_W'(fill_ff + PTR_W'(1));
         end
         for (int i = 0; i < HEAD_N; i++) begin
            if (sid_ff == msb_pkg::SID_W'(i)) begin
               head_in[i] = slot_ff;
            end
         end
      end else if (pop_ok) begin
         free_head_in = slot_ff;
         for (int i = 0; i < HEAD_N; i++) begin
            if (sid_ff == msb_pkg::SID_W'(i)) begin
               head_in[i] = link_eff;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_read_value_in = rsp_read_value_ff;
      rsp_status_in     = rsp_status_ff;
      if (ctrl.exec_fire) begin
         rsp_valid_in      = 1'b1;
         rsp_read_value_in = pop_ok ? data_q_ext : '0;
         if (go_ff) begin
            rsp_status_in = msb_pkg::STATUS_OK;
         end else if (is_push) begin
            rsp_status_in = msb_pkg::STATUS_OVERFLOW;
         end else begin
            rsp_status_in = msb_pkg::STATUS_EMPTY;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msb_pkg::ST_IDLE;
         free_head_ff <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < HEAD_N; i++) begin
            head_ff[i] <= NULL_PTR;
         end
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < HEAD_N; i++) begin
            head_ff[i] <= head_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_status_ff     <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= NULL_PTR)
      else $error("fill count ran past the slot store");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == msb_pkg::ST_EXEC))
      else $error("accepted request did not enter the write cycle");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == msb_pkg::ST_EXEC))
      else $error("response appeared without a write cycle");

   a_free_not_head: assert property (@(posedge clock) disable iff (reset)
      (free_head_ff != NULL_PTR) |-> (free_head_ff != head_ff[0]))
      else $error("free list and stack share a top slot");

endmodule
